// File: design/v4alu_pkg.sv
// v4alu_pkg: shared types, operation codes and saturation helper for the
// four-component vector arithmetic unit. No dependencies.
package v4alu_pkg;

	localparam int V4_DW    = 32;
	localparam int V4_FRAC  = 16;
	localparam int V4_LANES = 4;
	localparam int V4_CMD_W = 4;
	localparam int V4_WIDE  = 2 * V4_DW + 2;

	localparam logic [V4_CMD_W-1:0] CMD_ADD   = 4'd0;
	localparam logic [V4_CMD_W-1:0] CMD_SUB   = 4'd1;
	localparam logic [V4_CMD_W-1:0] CMD_NEG   = 4'd2;
	localparam logic [V4_CMD_W-1:0] CMD_SCALE = 4'd3;
	localparam logic [V4_CMD_W-1:0] CMD_DIV   = 4'd4;
	localparam logic [V4_CMD_W-1:0] CMD_DOT   = 4'd5;
	localparam logic [V4_CMD_W-1:0] CMD_SQMAG = 4'd6;
	localparam logic [V4_CMD_W-1:0] CMD_MAG   = 4'd7;
	localparam logic [V4_CMD_W-1:0] CMD_NORM  = 4'd8;

	localparam logic signed [V4_WIDE-1:0] V4_MAXW =
		{{(V4_WIDE-V4_DW+1){1'b0}}, {(V4_DW-1){1'b1}}};
	localparam logic signed [V4_WIDE-1:0] V4_MINW =
		{{(V4_WIDE-V4_DW+1){1'b1}}, {(V4_DW-1){1'b0}}};

	typedef logic signed [V4_DW-1:0] word_t;

	typedef struct packed {
		logic [V4_CMD_W-1:0] cmd;
		word_t a_x;
		word_t a_y;
		word_t a_z;
		word_t a_w;
		word_t b_x;
		word_t b_y;
		word_t b_z;
		word_t b_w;
		word_t scale_value;
	} req_t;

	typedef struct packed {
		word_t r_x;
		word_t r_y;
		word_t r_z;
		word_t r_w;
		logic  zero_divide;
		logic  saturated;
	} rsp_t;

	typedef struct packed {
		word_t val;
		logic  sat;
	} sat_word_t;

	typedef struct packed {
		logic [V4_CMD_W-1:0]             cmd;
		logic [V4_LANES-1:0]             aneg;
		logic [V4_LANES-1:0][V4_DW-1:0]  amag;
		logic                            sneg;
		logic [V4_DW-1:0]                smag;
	} hdr_t;

	typedef struct packed {
		hdr_t                        hdr;
		sat_word_t [V4_LANES-1:0]    vec;
		sat_word_t                   dot;
	} side_t;

	function automatic sat_word_t sat_clamp(input logic signed [V4_WIDE-1:0] v);
		sat_word_t r;
		if (v > V4_MAXW) begin
			r.val = V4_MAXW[V4_DW-1:0];
			r.sat = 1'b1;
		end else if (v < V4_MINW) begin
			r.val = V4_MINW[V4_DW-1:0];
			r.sat = 1'b1;
		end else begin
			r.val = v[V4_DW-1:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

endpackage

// File: design/v4alu_lane.sv
// v4alu_lane: one component lane, multiplier plus add/sub/negate and scale
// with saturation. Depends on v4alu_pkg.
module v4alu_lane import v4alu_pkg::*; #(
	parameter int FRAC_BITS = V4_FRAC
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [V4_CMD_W-1:0]         cmd,
	input  word_t                       a,
	input  word_t                       b,
	input  word_t                       s,
	output logic signed [2*V4_DW-1:0]   prod_s2,
	output sat_word_t                   res_s3
);

	word_t                        m;
	logic signed [V4_WIDE-1:0]    lin;
	logic [V4_CMD_W-1:0]          cmd_s2;
	sat_word_t                    lin_s2;
	logic signed [2*V4_DW-1:0]    shifted;

	always_comb begin
		case (cmd)
			CMD_SCALE: m = s;
			CMD_DOT:   m = b;
			default:   m = a;
		endcase
		case (cmd)
			CMD_ADD: lin = V4_WIDE'(a) + V4_WIDE'(b);
			CMD_SUB: lin = V4_WIDE'(a) - V4_WIDE'(b);
			CMD_NEG: lin = -V4_WIDE'(a);
			default: lin = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= a * m;
			cmd_s2  <= cmd;
			lin_s2  <= sat_clamp(lin);
		end
	end

	assign shifted = prod_s2 >>> FRAC_BITS;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s3 <= (cmd_s2 == CMD_SCALE) ? sat_clamp(V4_WIDE'(shifted)) : lin_s2;
		end
	end

endmodule

// File: design/v4alu_merge.sv
// v4alu_merge: combines the lane products into the dot product and the
// sum of squares. Depends on v4alu_pkg.
module v4alu_merge import v4alu_pkg::*; #(
	parameter int FRAC_BITS = V4_FRAC
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [2*V4_DW-1:0]   prod [V4_LANES],
	output sat_word_t                   dot_s3,
	output logic [2*V4_DW:0]            sqsum_s3
);

	logic signed [V4_WIDE-1:0] dsum;
	logic [2*V4_DW:0]          qsum;

	always_comb begin
		dsum = '0;
		qsum = '0;
		for (int i = 0; i < V4_LANES; i++) begin
			dsum = dsum + V4_WIDE'(prod[i] >>> FRAC_BITS);
			qsum = qsum + {1'b0, prod[i]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3   <= sat_clamp(dsum);
			sqsum_s3 <= qsum;
		end
	end

endmodule

// File: design/v4alu_sqrt.sv
// v4alu_sqrt: pipelined integer square root, one root bit per stage.
// Depends on v4alu_pkg.
module v4alu_sqrt import v4alu_pkg::*; (
	input  logic                 clk,
	input  logic                 en,
	input  logic [2*V4_DW:0]     radicand,
	output logic [V4_DW:0]       mag
);

	localparam int RW = V4_DW + 3;

	logic [RW-1:0]       rem_q  [V4_DW];
	logic [V4_DW-1:0]    root_q [V4_DW];
	logic [2*V4_DW-1:0]  rad_q  [V4_DW];
	logic                ovf_q  [V4_DW];

	for (genvar k = 0; k < V4_DW; k++) begin : g_stage
		logic [RW-1:0]       rem_in;
		logic [V4_DW-1:0]    root_in;
		logic [2*V4_DW-1:0]  rad_in;
		logic                ovf_in;
		logic [RW-1:0]       cur;
		logic [RW-1:0]       trial;

		if (k == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = radicand[2*V4_DW-1:0];
			assign ovf_in  = radicand[2*V4_DW];
		end else begin : g_next
			assign rem_in  = rem_q[k-1];
			assign root_in = root_q[k-1];
			assign rad_in  = rad_q[k-1];
			assign ovf_in  = ovf_q[k-1];
		end

		assign cur   = {rem_in[RW-3:0], rad_in[2*(V4_DW-1-k)+1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					rem_q[k]  <= cur - trial;
					root_q[k] <= {root_in[V4_DW-2:0], 1'b1};
				end else begin
					rem_q[k]  <= cur;
					root_q[k] <= {root_in[V4_DW-2:0], 1'b0};
				end
				rad_q[k] <= rad_in;
				ovf_q[k] <= ovf_in;
			end
		end
	end

	// all four components at the most negative value overflow the sum
	assign mag = ovf_q[V4_DW-1] ? {1'b1, {V4_DW{1'b0}}} : {1'b0, root_q[V4_DW-1]};

endmodule

// File: design/v4alu_div.sv
// v4alu_div: pipelined restoring divider for one lane, one quotient bit
// per stage. Depends on v4alu_pkg.
module v4alu_div import v4alu_pkg::*; #(
	parameter int FRAC_BITS = V4_FRAC
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [V4_DW+FRAC_BITS-1:0]    dividend,
	input  logic [V4_DW:0]                divisor,
	output logic [V4_DW+FRAC_BITS-1:0]    quo,
	output logic [V4_DW:0]                den,
	output logic                          dz
);

	localparam int QW = V4_DW + FRAC_BITS;

	logic [V4_DW:0]   rem_q [QW];
	logic [QW-1:0]    quo_q [QW];
	logic [QW-1:0]    num_q [QW];
	logic [V4_DW:0]   den_q [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [V4_DW:0]    rem_in;
		logic [QW-1:0]     quo_in;
		logic [QW-1:0]     num_in;
		logic [V4_DW:0]    den_in;
		logic [V4_DW+1:0]  cur;
		logic [V4_DW+1:0]  diff;
		logic              ge;

		if (j == 0) begin : g_first
			assign rem_in = '0;
			assign quo_in = '0;
			assign num_in = dividend;
			assign den_in = divisor;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign quo_in = quo_q[j-1];
			assign num_in = num_q[j-1];
			assign den_in = den_q[j-1];
		end

		assign cur  = {rem_in, num_in[QW-1-j]};
		assign diff = cur - {1'b0, den_in};
		assign ge   = (cur >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= ge ? diff[V4_DW:0] : cur[V4_DW:0];
				quo_q[j] <= {quo_in[QW-2:0], ge};
				num_q[j] <= num_in;
				den_q[j] <= den_in;
			end
		end
	end

	assign quo = quo_q[QW-1];
	assign den = den_q[QW-1];
	assign dz  = (den_q[QW-1] == '0);

endmodule

// File: design/vec4_arith_unit_core.sv
// vec4_arith_unit_core: four-component Q16.16 vector arithmetic unit, top level.
// Uses v4alu_pkg, v4alu_lane, v4alu_merge, v4alu_sqrt and v4alu_div.
//
// Takes one item per cycle and returns one result per item, in order. The
// square root pipeline (one root bit per stage) is followed by the four lane
// dividers (one quotient bit per stage); every operation passes through both
// so results keep their order.
// When the output holds a result that is stalled, the whole pipeline holds
// and req_stall is raised; otherwise the unit keeps accepting every cycle.
module vec4_arith_unit_core import v4alu_pkg::*; #(
	parameter int FRAC_BITS = V4_FRAC
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	localparam int QW = V4_DW + FRAC_BITS;
	localparam int NS = V4_DW + QW;
	localparam int NV = 3 + NS;

	logic                         adv;
	logic [NV-1:0]                vld_q;
	logic                         rsp_valid_q;
	rsp_t                         rsp_q;
	rsp_t                         rsp_d;
	req_t                         item_s1;
	word_t                        a_v [V4_LANES];
	word_t                        b_v [V4_LANES];
	hdr_t                         hdr_d;
	hdr_t                         hdr_s2;
	hdr_t                         hdr_s3;
	logic signed [2*V4_DW-1:0]    prod_s2 [V4_LANES];
	sat_word_t                    vec_s3  [V4_LANES];
	sat_word_t                    dot_s3;
	logic [2*V4_DW:0]             sqsum_s3;
	logic [V4_DW:0]               mag;
	side_t                        side0;
	side_t                        side_q [NS];
	side_t                        ent;
	side_t                        fin;
	logic [V4_DW:0]               divisor;
	logic [QW-1:0]                quo [V4_LANES];
	logic [V4_DW:0]               den [V4_LANES];
	logic                         dz  [V4_LANES];
	word_t                        rv  [V4_LANES];
	sat_word_t                    cw;
	logic signed [V4_WIDE-1:0]    qv;
	logic                         qneg;

	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[NV-2:0], req_valid};
			rsp_valid_q <= vld_q[NV-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= req_data;
		end
	end

	assign a_v[0] = item_s1.a_x;
	assign a_v[1] = item_s1.a_y;
	assign a_v[2] = item_s1.a_z;
	assign a_v[3] = item_s1.a_w;
	assign b_v[0] = item_s1.b_x;
	assign b_v[1] = item_s1.b_y;
	assign b_v[2] = item_s1.b_z;
	assign b_v[3] = item_s1.b_w;

	always_comb begin
		hdr_d.cmd  = item_s1.cmd;
		hdr_d.sneg = item_s1.scale_value[V4_DW-1];
		hdr_d.smag = item_s1.scale_value[V4_DW-1] ? V4_DW'(-item_s1.scale_value)
		                                          : V4_DW'(item_s1.scale_value);
		for (int i = 0; i < V4_LANES; i++) begin
			hdr_d.aneg[i] = a_v[i][V4_DW-1];
			hdr_d.amag[i] = a_v[i][V4_DW-1] ? V4_DW'(-a_v[i]) : V4_DW'(a_v[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			hdr_s2 <= hdr_d;
			hdr_s3 <= hdr_s2;
		end
	end

	for (genvar i = 0; i < V4_LANES; i++) begin : g_lane
		v4alu_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk     (clk),
			.en      (adv),
			.cmd     (item_s1.cmd),
			.a       (a_v[i]),
			.b       (b_v[i]),
			.s       (item_s1.scale_value),
			.prod_s2 (prod_s2[i]),
			.res_s3  (vec_s3[i])
		);
	end

	v4alu_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
		.clk      (clk),
		.en       (adv),
		.prod     (prod_s2),
		.dot_s3   (dot_s3),
		.sqsum_s3 (sqsum_s3)
	);

	v4alu_sqrt u_sqrt (
		.clk      (clk),
		.en       (adv),
		.radicand (sqsum_s3),
		.mag      (mag)
	);

	always_comb begin
		side0.hdr = hdr_s3;
		side0.dot = dot_s3;
		for (int i = 0; i < V4_LANES; i++) begin
			side0.vec[i] = vec_s3[i];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side0;
			for (int i = 1; i < NS; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	assign ent     = side_q[V4_DW-1];
	assign fin     = side_q[NS-1];
	assign divisor = (ent.hdr.cmd == CMD_DIV) ? {1'b0, ent.hdr.smag} : mag;

	for (genvar i = 0; i < V4_LANES; i++) begin : g_div
		v4alu_div #(.FRAC_BITS(FRAC_BITS)) u_div (
			.clk      (clk),
			.en       (adv),
			.dividend ({ent.hdr.amag[i], {FRAC_BITS{1'b0}}}),
			.divisor  (divisor),
			.quo      (quo[i]),
			.den      (den[i]),
			.dz       (dz[i])
		);
	end

	always_comb begin
		rsp_d = '0;
		cw    = '0;
		qv    = '0;
		qneg  = 1'b0;
		for (int i = 0; i < V4_LANES; i++) begin
			rv[i] = '0;
		end
		unique case (fin.hdr.cmd) inside
			CMD_ADD, CMD_SUB, CMD_NEG, CMD_SCALE: begin
				for (int i = 0; i < V4_LANES; i++) begin
					rv[i]           = fin.vec[i].val;
					rsp_d.saturated = rsp_d.saturated | fin.vec[i].sat;
				end
			end
			CMD_DIV, CMD_NORM: begin
				if (dz[0]) begin
					rsp_d.zero_divide = 1'b1;
				end else begin
					for (int i = 0; i < V4_LANES; i++) begin
						qneg = fin.hdr.aneg[i] ^ ((fin.hdr.cmd == CMD_DIV) && fin.hdr.sneg);
						qv   = $signed({{(V4_WIDE-QW){1'b0}}, quo[i]});
						if (qneg) begin
							qv = -qv;
						end
						cw              = sat_clamp(qv);
						rv[i]           = cw.val;
						rsp_d.saturated = rsp_d.saturated | cw.sat;
					end
				end
			end
			CMD_DOT, CMD_SQMAG: begin
				rv[0]           = fin.dot.val;
				rsp_d.saturated = fin.dot.sat;
			end
			CMD_MAG: begin
				cw              = sat_clamp($signed({{(V4_WIDE-V4_DW-1){1'b0}}, den[0]}));
				rv[0]           = cw.val;
				rsp_d.saturated = cw.sat;
			end
			default: begin
				rsp_d = '0;
			end
		endcase
		rsp_d.r_x = rv[0];
		rsp_d.r_y = rv[1];
		rsp_d.r_z = rv[2];
		rsp_d.r_w = rv[3];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

// File: design/v4alu_checker.sv
// v4alu_checker: port-level assertions for vec4_arith_unit_core, bound to it.
// Depends on v4alu_pkg.
module v4alu_checker import v4alu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req_data,
	input logic rsp_valid,
	input logic rsp_stall,
	input rsp_t rsp_data
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled result item changed");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("input stalled without a stalled result item");

	a_zd_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.zero_divide |-> !rsp_data.saturated)
		else $error("zero divide item flagged as saturated");

	a_zd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.zero_divide |->
			rsp_data.r_x == '0 && rsp_data.r_y == '0 &&
			rsp_data.r_z == '0 && rsp_data.r_w == '0)
		else $error("zero divide item has nonzero components");

endmodule

bind vec4_arith_unit_core v4alu_checker u_v4alu_checker (.*);
